>>> design/fla_pkg.sv
// Shared constants, types and state codes of the free-list block allocator.
// No dependencies; fla_in_if and the top level use this package.
package fla_pkg;

  localparam int HEAP_BYTES   = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int HEAP_COUNT   = 3;
  localparam int UNITS        = HEAP_BYTES / 8;
  localparam int UNIT_W       = $clog2(UNITS);
  localparam int LINK_W       = UNIT_W + 1;
  localparam int SIZE_W       = 10;
  localparam int HEAP_W       = 2;
  localparam int DEPTH        = HEAP_COUNT * UNITS;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int WIDE_W       = SIZE_W + 2;
  localparam int STEP_W       = UNIT_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(UNITS);
  localparam logic [SIZE_W-1:0] INIT_SIZE  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [WIDE_W-1:0] HDR_WIDE   = WIDE_W'(HEADER_BYTES);
  localparam logic [WIDE_W-1:0] HEAP_WIDE  = WIDE_W'(HEAP_BYTES);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_FIN   = 7'b0001000,
    ST_WR1   = 7'b0010000,
    ST_WR2   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

endpackage

>>> design/fla_in_if.sv
// Input channel of the allocator: valid/ready plus one request word.
// Depends on fla_pkg for field widths.
interface fla_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fla_pkg::HEAP_W-1:0] heap_sel;
  logic [9:0]                request_bytes;
  logic [9:0]                payload_offset_in;
  modport source (output valid, op, heap_sel, request_bytes, payload_offset_in, input ready);
  modport sink   (input valid, op, heap_sel, request_bytes, payload_offset_in, output ready);
endinterface

>>> design/fla_out_if.sv
// Output channel of the allocator: valid/ready plus one result word.
// No dependencies.
interface fla_out_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic [9:0] payload_offset_out;
  modport source (output valid, success, payload_offset_out, input ready);
  modport sink   (input valid, success, payload_offset_out, output ready);
endinterface

>>> design/fla_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> design/free_list_block_allocator_top.sv
// Top level of the free-list block allocator: sequencer over two header RAMs.
// Depends on fla_pkg, fla_in_if, fla_out_if and fla_ram.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+------------------------------------------
//  in_i     | in  | valid/ready        | op, heap_sel, request_bytes, payload_offset_in
//  out_o    | out | valid/ready        | success, payload_offset_out
//  fit_mode | in  | fit_mode_we_i      | fit_mode_i (0 best fit, 1 first fit)
//
// From the accepting edge an item passes through ST_START, one ST_WALK state per
// free-list block visited and ST_FIN, then ST_WR1 and ST_WR2 when the lists are
// written, before ST_DONE; the walk is bound by the registered read of the link
// RAM. Invalid heaps and bad free addresses go from ST_START to ST_DONE. The
// next word is taken in ST_IDLE, which follows the loading of the result.
// Reset needs no clearing pass: per-heap flags stand in for unit zero.
// A new word is taken while the previous result still waits on out_o; the
// sequencer holds in its final state only if a second result is ready.
module free_list_block_allocator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fit_mode_we_i,
  input  logic      fit_mode_i,
  fla_in_if.sink    in_i,
  fla_out_if.source out_o
);
  import fla_pkg::*;

  state_e state_q, state_d;

  logic                  fit_mode_q;
  logic                  op_q;
  logic [HEAP_W-1:0]     heap_q;
  logic [WIDE_W-1:0]     min_q;
  logic [WIDE_W-1:0]     need_q;
  logic [UNIT_W-1:0]     tgt_q;
  logic                  bad_q;
  logic [LINK_W-1:0]     cur_q;
  logic [UNIT_W-1:0]     prev_q;
  logic                  prev_none_q;
  logic [STEP_W-1:0]     steps_q;
  logic                  best_ok_q;
  logic [UNIT_W-1:0]     best_q;
  logic [UNIT_W-1:0]     best_prev_q;
  logic                  best_prev_none_q;
  logic [SIZE_W-1:0]     best_sz_q;
  logic [LINK_W-1:0]     best_link_q;
  logic [WIDE_W-1:0]     diff_q;
  logic                  res_ok_q;
  logic [UNIT_W-1:0]     head_q      [HEAP_COUNT];
  logic [HEAP_COUNT-1:0] size_init_q;
  logic [HEAP_COUNT-1:0] link_init_q;
  logic                  out_valid_q;
  logic                  out_success_q;
  logic [9:0]            out_offset_q;

  // RAM ports
  logic                  size_we, link_we;
  logic [ADDR_W-1:0]     size_addr, link_addr;
  logic [SIZE_W-1:0]     size_wdata, size_rdata;
  logic [LINK_W-1:0]     link_wdata, link_rdata;
  logic [UNIT_W-1:0]     rd_unit;
  logic [UNIT_W-1:0]     size_wunit, link_wunit;

  fla_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (size_we),
    .addr_i (size_addr),
    .wdata_i(size_wdata),
    .rdata_o(size_rdata)
  );

  fla_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .addr_i (link_addr),
    .wdata_i(link_wdata),
    .rdata_o(link_rdata)
  );

  function automatic logic [ADDR_W-1:0] mem_addr(logic [HEAP_W-1:0] h, logic [UNIT_W-1:0] u);
    return ADDR_W'(h) * ADDR_W'(UNITS) + ADDR_W'(u);
  endfunction

  // Unit zero of an untouched heap reads as the reset header.
  logic              unit0;
  logic [SIZE_W-1:0] sz_rd;
  logic [LINK_W-1:0] lk_rd;
  assign unit0 = (cur_q == '0);
  assign sz_rd = (unit0 && size_init_q[heap_q]) ? INIT_SIZE : size_rdata;
  assign lk_rd = (unit0 && link_init_q[heap_q]) ? NULL_LINK : link_rdata;

  // Walk evaluation for the block held in cur_q
  logic [WIDE_W-1:0] sz_w, end_w, slack_w;
  logic              fits, better;
  logic [STEP_W-1:0] steps_nx;
  assign sz_w     = WIDE_W'(sz_rd);
  assign end_w    = WIDE_W'({cur_q[UNIT_W-1:0], 3'b000}) + HDR_WIDE + sz_w;
  assign fits     = (sz_w >= need_q) && (end_w <= HEAP_WIDE);
  assign slack_w  = sz_w - need_q;
  assign better   = fits && (slack_w < diff_q);
  assign steps_nx = steps_q + STEP_W'(1);

  function automatic logic go_on(logic op, logic [LINK_W-1:0] c, logic [STEP_W-1:0] s,
                                 logic [UNIT_W-1:0] t);
    logic ok;
    ok = (c < NULL_LINK) && (s < STEP_W'(UNITS));
    if (op == OP_FREE) begin
      ok = ok && (c < LINK_W'(t));
    end
    return ok;
  endfunction

  logic [UNIT_W-1:0] nu;
  assign nu = best_q + UNIT_W'(need_q[WIDE_W-1:3]);

  logic in_fire, out_room;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_room   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d    = state_q;
    rd_unit    = cur_q[UNIT_W-1:0];
    size_we    = 1'b0;
    link_we    = 1'b0;
    size_wunit = '0;
    link_wunit = '0;
    size_wdata = '0;
    link_wdata = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_START;
      end
      ST_START: begin
        rd_unit = head_q[heap_q];
        if (bad_q) begin
          state_d = ST_DONE;
        end else if (go_on(op_q, LINK_W'(head_q[heap_q]), '0, tgt_q)) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_WALK: begin
        rd_unit = lk_rd[UNIT_W-1:0];
        if (op_q == OP_ALLOC && fit_mode_q && fits) begin
          state_d = ST_FIN;
        end else if (!go_on(op_q, lk_rd, steps_nx, tgt_q)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (op_q == OP_ALLOC) begin
          state_d = best_ok_q ? ST_WR1 : ST_DONE;
        end else begin
          state_d = (cur_q == LINK_W'(tgt_q)) ? ST_DONE : ST_WR1;
        end
      end
      ST_WR1: begin
        link_we = 1'b1;
        if (op_q == OP_ALLOC) begin
          size_we    = 1'b1;
          size_wunit = best_q;
          size_wdata = min_q[SIZE_W-1:0];
          link_wunit = nu;
          link_wdata = best_link_q;
        end else begin
          link_wunit = tgt_q;
          link_wdata = (cur_q < NULL_LINK) ? cur_q : NULL_LINK;
        end
        state_d = ST_WR2;
      end
      ST_WR2: begin
        if (op_q == OP_ALLOC) begin
          size_we    = 1'b1;
          size_wunit = nu;
          size_wdata = best_sz_q - need_q[SIZE_W-1:0];
          link_we    = !best_prev_none_q;
          link_wunit = best_prev_q;
          link_wdata = LINK_W'(nu);
        end else begin
          link_we    = !prev_none_q;
          link_wunit = prev_q;
          link_wdata = LINK_W'(tgt_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_room) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign size_addr = mem_addr(heap_q, size_we ? size_wunit : rd_unit);
  assign link_addr = mem_addr(heap_q, link_we ? link_wunit : rd_unit);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fit_mode_q  <= 1'b1;
      size_init_q <= '1;
      link_init_q <= '1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HEAP_COUNT; i++) head_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (fit_mode_we_i) fit_mode_q <= fit_mode_i;
      // drop the unit-zero stand-in once the real entry is written
      if (size_we && size_wunit == '0) size_init_q[heap_q] <= 1'b0;
      if (link_we && link_wunit == '0) link_init_q[heap_q] <= 1'b0;
      if (state_q == ST_WR2) begin
        if (op_q == OP_ALLOC && best_prev_none_q) head_q[heap_q] <= nu;
        if (op_q == OP_FREE && prev_none_q) head_q[heap_q] <= tgt_q;
      end
      if (state_q == ST_DONE && out_room) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current item
  logic [9:0] hdr;
  always_comb hdr = in_i.payload_offset_in - 10'(HEADER_BYTES);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q     <= in_i.op;
        heap_q   <= in_i.heap_sel;
        min_q    <= (WIDE_W'(in_i.request_bytes) + WIDE_W'(7)) & ~WIDE_W'(7);
        need_q   <= ((WIDE_W'(in_i.request_bytes) + WIDE_W'(7)) & ~WIDE_W'(7)) + HDR_WIDE;
        tgt_q    <= hdr[UNIT_W+2:3];
        bad_q    <= (in_i.heap_sel >= HEAP_W'(HEAP_COUNT)) ||
                    (in_i.op == OP_FREE &&
                     ((in_i.payload_offset_in < 10'(HEADER_BYTES)) || (hdr[2:0] != 3'b000)));
        res_ok_q <= 1'b0;
      end
      ST_START: begin
        cur_q            <= LINK_W'(head_q[heap_q]);
        prev_none_q      <= 1'b1;
        steps_q          <= '0;
        best_ok_q        <= 1'b0;
        best_prev_none_q <= 1'b1;
        diff_q           <= HEAP_WIDE;
      end
      ST_WALK: begin
        if (op_q == OP_ALLOC && (fit_mode_q ? fits : better)) begin
          best_ok_q        <= 1'b1;
          best_q           <= cur_q[UNIT_W-1:0];
          best_prev_q      <= prev_q;
          best_prev_none_q <= prev_none_q;
          best_sz_q        <= sz_rd;
          best_link_q      <= lk_rd;
          diff_q           <= slack_w;
        end
        prev_q      <= cur_q[UNIT_W-1:0];
        prev_none_q <= 1'b0;
        cur_q       <= lk_rd;
        steps_q     <= steps_nx;
      end
      ST_WR2: res_ok_q <= 1'b1;
      default: ;
    endcase
  end

  // Result register: hold until taken, load once the slot frees
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_room) begin
      out_success_q <= res_ok_q;
      out_offset_q  <= (res_ok_q && op_q == OP_ALLOC) ?
                       10'({best_q, 3'b000}) + 10'(HEADER_BYTES) : '0;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.success            = out_success_q;
  assign out_o.payload_offset_out = out_offset_q;

endmodule
